// File: rtl/cmta_pkg.sv
// shared constants, types and state codes for the cycle count to millisecond accumulator
// no dependencies; every other file imports this package
`timescale 1ns / 1ps

package cmta_pkg;

    // stamp bits actually used (32 to 64), and the fixed field widths of the ports
    localparam int STAMP_WIDTH = 64;
    localparam int STAMP_IN_W  = 64;
    localparam int FREQ_W      = 34;
    localparam int ADDED_W     = 55;
    localparam int TOTAL_W     = 64;

    // elapsed * 1000 needs ten more bits than the stamp
    localparam int DQ_W   = STAMP_WIDTH + 10;
    localparam int CNT_W  = $clog2(DQ_W + 1);
    // remainder plus 999, for the rounded-up remainder in cycles per ms
    localparam int CEIL_W = FREQ_W + 1;

    localparam logic [FREQ_W-1:0] FREQ_MIN   = FREQ_W'(1000000);
    localparam logic [FREQ_W-1:0] FREQ_RESET = FREQ_W'(25000000);
    localparam logic [FREQ_W-1:0] MS_PER_S   = FREQ_W'(1000);
    localparam logic [CEIL_W-1:0] CEIL_BIAS  = CEIL_W'(999);

    localparam logic [CNT_W-1:0] STEPS_MS   = CNT_W'(DQ_W);
    localparam logic [CNT_W-1:0] STEPS_CEIL = CNT_W'(CEIL_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ELAPSED,
        S_SCALE,
        S_LOAD,
        S_DIV_MS,
        S_DIV_CEIL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] steps;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// File: rtl/cmta_if.sv
// valid/ready channel interfaces for stamp beats in and result beats out
// depends on cmta_pkg for field widths
`timescale 1ns / 1ps

interface cmta_in_if;
    import cmta_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [STAMP_IN_W-1:0] stamp;

    modport source (output valid, output stamp, input ready);
    modport sink   (input valid, input stamp, output ready);
endinterface

interface cmta_out_if;
    import cmta_pkg::*;

    logic               valid;
    logic               ready;
    logic [ADDED_W-1:0] added_ms;
    logic [TOTAL_W-1:0] total_ms;
    logic               first_sample;

    modport source (output valid, output added_ms, output total_ms, output first_sample,
                    input ready);
    modport sink   (input valid, input added_ms, input total_ms, input first_sample,
                    output ready);
endinterface

// File: rtl/cmta_serdiv.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on cmta_pkg; dividend is left aligned, quotient shifts into the low bits
`timescale 1ns / 1ps

module cmta_serdiv (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cmta_pkg::t_div_ctl         i_ctl,
    input  logic [cmta_pkg::DQ_W-1:0]   i_dividend,
    input  logic [cmta_pkg::FREQ_W-1:0] i_divisor,
    output cmta_pkg::t_div_sts         o_sts,
    output logic [cmta_pkg::DQ_W-1:0]   o_quot,
    output logic [cmta_pkg::FREQ_W-1:0] o_rem
);
    import cmta_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [FREQ_W-1:0] r_rem;
    logic [DQ_W-1:0]   r_dq;
    logic [FREQ_W-1:0] r_div;

    logic [FREQ_W:0]   w_trial;
    logic [FREQ_W+1:0] w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_dq[DQ_W-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_div};
    assign w_ge    = ~w_diff[FREQ_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_dq  <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits the divisor width
            r_rem <= w_ge ? w_diff[FREQ_W-1:0] : w_trial[FREQ_W-1:0];
            r_dq  <= {r_dq[DQ_W-2:0], w_ge};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_dq;
    assign o_rem      = r_rem;

`ifndef ASSERT_OFF
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |=> r_busy)
        else $error("divider not busy after start");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a run");
    a_last_step_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_cnt == CNT_W'(1)) && !i_ctl.start) |=> r_done)
        else $error("divider missed its done pulse");
`endif

endmodule

// File: rtl/cycle_count_to_millisecond_accumulator.sv
// top level: sequencer, stamp and total state, output register
// depends on cmta_pkg, cmta_if (channel interfaces) and cmta_serdiv
`timescale 1ns / 1ps

// channel     dir  width             beat contents
// i_in        in   64                stamp (low STAMP_WIDTH bits used)
// o_out       out  55 + 64 + 1       added_ms, total_ms, first_sample
// i_cfg_*     in   34                cycles_per_second, write only
//
// a priming beat (stored stamp zero) goes from accept straight to the done state
// other beats pass the elapsed, scale and load states, run the serial divider for
// elapsed * 1000 / freq, and when that is nonzero run it again for ceil(rem / 1000),
// then load the result in the done state once the output register is free
// one shared bit-serial divider serves both runs; one beat is in work at a time
// reset is synchronous active low: stamp unprimed, total zero, frequency 25 MHz
// a stalled output holds in its register while the next stamp beat is accepted

module cycle_count_to_millisecond_accumulator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [cmta_pkg::FREQ_W-1:0] i_cfg_wdata,
    cmta_in_if.sink                     i_in,
    cmta_out_if.source                  o_out
);
    import cmta_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [FREQ_W-1:0]      r_freq;
    logic [STAMP_WIDTH-1:0] r_last;
    logic [TOTAL_W-1:0]     r_total;

    logic [STAMP_WIDTH-1:0] r_now;
    logic [STAMP_WIDTH-1:0] r_elap;
    logic [DQ_W-1:0]        r_num;
    logic [ADDED_W-1:0]     r_added;
    logic                   r_first;

    logic                   r_out_valid;
    logic [ADDED_W-1:0]     r_out_added;
    logic [TOTAL_W-1:0]     r_out_total;
    logic                   r_out_first;

    t_div_ctl          w_div_ctl;
    t_div_sts          w_div_sts;
    logic [DQ_W-1:0]   w_dividend;
    logic [FREQ_W-1:0] w_divisor;
    logic [DQ_W-1:0]   w_quot;
    logic [FREQ_W-1:0] w_rem;

    logic [STAMP_WIDTH-1:0] w_stamp;
    logic                   w_accept;
    logic                   w_primed;
    logic                   w_quot_nz;
    logic                   w_slot_free;
    logic [DQ_W-1:0]        w_scaled;
    logic [CEIL_W-1:0]      w_ceil;

    assign w_stamp     = i_in.stamp[STAMP_WIDTH-1:0];
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_primed    = (r_last != '0);
    assign w_quot_nz   = (w_quot != '0);
    assign w_slot_free = !r_out_valid || o_out.ready;

    // elapsed * 1000 as elapsed * 1024 - elapsed * 16 - elapsed * 8, last term here
    assign w_scaled = r_num - DQ_W'({r_elap, 3'b000});
    // rounding the remainder up gives the cycles still owed after whole ms
    assign w_ceil   = {1'b0, w_rem} + CEIL_BIAS;

    cmta_serdiv u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_sts      (w_div_sts),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_primed ? S_ELAPSED : S_DONE;
                end
            end
            S_ELAPSED: n_state = S_SCALE;
            S_SCALE:   n_state = S_LOAD;
            S_LOAD:    n_state = S_DIV_MS;
            S_DIV_MS: begin
                if (w_div_sts.done) begin
                    n_state = w_quot_nz ? S_DIV_CEIL : S_DONE;
                end
            end
            S_DIV_CEIL: begin
                if (w_div_sts.done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: input ready and divider launches
    always_comb begin
        i_in.ready      = 1'b0;
        w_div_ctl.start = 1'b0;
        w_div_ctl.steps = STEPS_MS;
        w_dividend      = w_scaled;
        w_divisor       = r_freq;
        unique case (r_state)
            S_IDLE: i_in.ready = 1'b1;
            S_LOAD: w_div_ctl.start = 1'b1;
            S_DIV_MS: begin
                if (w_div_sts.done && w_quot_nz) begin
                    // second run: ceil(rem / 1000), dividend left aligned
                    w_div_ctl.start = 1'b1;
                    w_div_ctl.steps = STEPS_CEIL;
                    w_dividend      = {w_ceil, {(DQ_W - CEIL_W){1'b0}}};
                    w_divisor       = MS_PER_S;
                end
            end
            S_ELAPSED, S_SCALE, S_DIV_CEIL, S_DONE: ;
            default: ;
        endcase
    end

    // state, frequency register and the two accumulated values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_freq  <= FREQ_RESET;
            r_last  <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                // frequencies below 1 MHz act as 1 MHz
                r_freq <= (i_cfg_wdata < FREQ_MIN) ? FREQ_MIN : i_cfg_wdata;
            end
            if (w_accept && !w_primed) begin
                r_last <= w_stamp;
            end
            if ((r_state == S_DIV_CEIL) && w_div_sts.done) begin
                // stamp + floor(freq * ms / 1000) equals now - ceil(rem / 1000)
                r_last  <= r_now - STAMP_WIDTH'(w_quot[CEIL_W-1:0]);
                r_total <= r_total + TOTAL_W'(r_added);
            end
        end
    end

    // per-beat working registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now   <= w_stamp;
            r_first <= !w_primed;
            r_added <= '0;
        end
        if (r_state == S_ELAPSED) begin
            r_elap <= r_now - r_last;
        end
        if (r_state == S_SCALE) begin
            r_num <= {r_elap, 10'b0} - DQ_W'({r_elap, 4'b0000});
        end
        if ((r_state == S_DIV_MS) && w_div_sts.done) begin
            r_added <= ADDED_W'(w_quot);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && w_slot_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_slot_free) begin
            r_out_added <= r_added;
            r_out_total <= r_total;
            r_out_first <= r_first;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.added_ms     = r_out_added;
    assign o_out.total_ms     = r_out_total;
    assign o_out.first_sample = r_out_first;

`ifndef ASSERT_OFF
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_ctl.start |-> !w_div_sts.busy)
        else $error("divider launched while busy");
    a_prime_adds_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_first) |-> (r_out_added == '0))
        else $error("priming beat credited milliseconds");
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !i_in.ready)
        else $error("second stamp accepted while one is in work");
`endif

endmodule

// File: tb/cycle_count_to_millisecond_accumulator_tb.sv
// self-checking testbench for the cycle count to millisecond accumulator
// depends on cmta_pkg, cmta_if and the rtl top; drives stamp beats and checks every result beat
`timescale 1ns / 1ps

module cycle_count_to_millisecond_accumulator_tb;
    import cmta_pkg::*;

    // run time guard, several times the slowest legal run
    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int unsigned ROWS        = 24;
    localparam int unsigned REPORT_MAX  = 10;
    localparam logic [63:0] STAMP_KEEP  = {64{1'b1}} >> (64 - STAMP_WIDTH);
    localparam logic [FREQ_W-1:0] FREQ_TOP = {FREQ_W{1'b1}};

    typedef struct packed {
        logic [ADDED_W-1:0] added_ms;
        logic [TOTAL_W-1:0] total_ms;
        logic               first_sample;
    } t_ms_beat;

    typedef enum logic [1:0] {
        ROW_STAMP,   // absolute stamp
        ROW_DELTA,   // stamp = stored stamp + value
        ROW_CFG      // frequency register write
    } t_row_kind;

    typedef struct packed {
        t_row_kind kind;
        logic [63:0] value;
        logic        typed;
        t_ms_beat    beat;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [FREQ_W-1:0] i_cfg_wdata;

    cmta_in_if  in_ch ();
    cmta_out_if out_ch ();

    cycle_count_to_millisecond_accumulator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // predictor state: stored stamp, running total, frequency register
    logic [63:0]       stored_stamp;
    logic [63:0]       run_total;
    logic [FREQ_W-1:0] cfg_freq;

    t_ms_beat pending_ms [$];
    t_row     plan [ROWS];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned cycle_cnt;
    int unsigned mismatches;
    int unsigned beats_sent;
    int unsigned results_seen;
    int unsigned primes_seen;
    int unsigned total_wraps;
    int unsigned freq_writes;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_cnt, pending_ms.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // register value below range counts as the minimum frequency
    function automatic logic [FREQ_W-1:0] eff_freq();
        logic [FREQ_W-1:0] f;
        f = cfg_freq;
        if (f < FREQ_MIN) f = FREQ_MIN;
        return f;
    endfunction

    // advance the predictor by one stamp beat and return the result it must produce
    function automatic t_ms_beat credit_ms(input logic [63:0] stamp);
        t_ms_beat     r;
        logic [63:0]  now;
        logic [63:0]  elapsed;
        logic [63:0]  adv;
        logic [63:0]  old_total;
        logic [127:0] num;
        logic [127:0] quo;
        r = '0;
        now = stamp & STAMP_KEEP;
        if (stored_stamp == 64'd0) begin
            // priming beat: record only
            stored_stamp = now;
            r.first_sample = 1'b1;
            primes_seen++;
        end else begin
            elapsed = (now - stored_stamp) & STAMP_KEEP;
            num = 128'(elapsed) * 128'd1000;
            quo = num / 128'(eff_freq());
            r.added_ms = quo[ADDED_W-1:0];
            if (quo != 128'd0) begin
                old_total = run_total;
                run_total = run_total + quo[63:0];
                if (run_total < old_total) total_wraps++;
                // stamp moves by whole ms worth of cycles, remainder carries
                num = 128'(eff_freq()) * quo;
                adv = 64'(num / 128'd1000);
                stored_stamp = (stored_stamp + adv) & STAMP_KEEP;
            end
        end
        r.total_ms = run_total;
        return r;
    endfunction

    function automatic t_row mk_row(input t_row_kind kind, input logic [63:0] value,
                                    input logic typed, input logic [63:0] added,
                                    input logic [63:0] total, input logic first);
        t_row r;
        r.kind = kind;
        r.value = value;
        r.typed = typed;
        r.beat.added_ms = added[ADDED_W-1:0];
        r.beat.total_ms = total;
        r.beat.first_sample = first;
        return r;
    endfunction

    // one stamp beat, with an optional sender gap ahead of it
    task automatic send_stamp(input logic [63:0] s, input logic typed,
                              input t_ms_beat typed_beat);
        int unsigned gap;
        t_ms_beat    predicted;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 130);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.stamp <= s;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predicted = credit_ms(s);
        pending_ms.push_back(typed ? typed_beat : predicted);
        beats_sent++;
    endtask

    // hold the sender off until every owed result has been taken
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_ms.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_freq(input logic [FREQ_W-1:0] v);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        cfg_freq = v;
        freq_writes++;
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [FREQ_W-1:0] pick_freq();
        logic [FREQ_W-1:0] f;
        f = {2'($urandom_range(0, 3)), $urandom};
        case ($urandom_range(0, 7))
            0: f = FREQ_RESET;
            1: f = FREQ_TOP;
            2: f = '0;
            3: f = FREQ_MIN - 1;
            4: f = FREQ_MIN;
            5: f = FREQ_MIN + 1;
            6: if (f < FREQ_MIN) f = f + FREQ_MIN;
            default: ;
        endcase
        return f;
    endfunction

    // mostly well-formed tick spacing of zero to thirteen ms, plus noise and wrapping stamps
    function automatic logic [63:0] pick_stamp();
        logic [63:0] per_ms;
        logic [63:0] delta;
        int unsigned sel;
        per_ms = 64'(eff_freq()) / 64'd1000;
        sel = $urandom_range(99);
        if (sel < 55) begin
            delta = per_ms * 64'($urandom_range(0, 12)) + 64'($urandom_range(0, per_ms[31:0]));
        end else if (sel < 65) begin
            delta = per_ms - 64'($urandom_range(1, 3));
        end else if (sel < 80) begin
            return {$urandom, $urandom};
        end else if (sel < 87) begin
            delta = {64{1'b1}} - 64'($urandom_range(0, 3));
        end else if (sel < 94) begin
            delta = 64'($urandom_range(0, 3));
        end else if (sel < 97) begin
            return 64'd0;
        end else begin
            delta = {$urandom, $urandom} >> $urandom_range(0, 63);
        end
        return stored_stamp + delta;
    endfunction

    // result side: random stalls, every beat checked against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_ms_beat want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (pending_ms.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result beat: added %0d total %0d first %0d",
                                 out_ch.added_ms, out_ch.total_ms, out_ch.first_sample);
                end else begin
                    want = pending_ms.pop_front();
                    if (out_ch.added_ms !== want.added_ms ||
                        out_ch.total_ms !== want.total_ms ||
                        out_ch.first_sample !== want.first_sample) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display({"result %0d mismatch: added %0d/%0d total %0d/%0d ",
                                      "first %0d/%0d (expected/actual)"},
                                     results_seen, want.added_ms, out_ch.added_ms,
                                     want.total_ms, out_ch.total_ms,
                                     want.first_sample, out_ch.first_sample);
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin : stimulus
        int unsigned i;
        int unsigned phase;
        int unsigned sub;
        int unsigned n;
        in_ch.valid <= 1'b0;
        in_ch.stamp <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        i_rst_n <= 1'b0;
        beats_sent = 0;
        primes_seen = 0;
        total_wraps = 0;
        freq_writes = 0;
        stored_stamp = '0;
        run_total = '0;
        cfg_freq = FREQ_RESET;
        send_idle_pct = 15;
        recv_idle_pct = 82;

        // 2^64 mod 25000 is 1616, so priming at 1616 lets the wrap land the stamp on zero
        plan[0]  = mk_row(ROW_STAMP, 64'd1616, 1'b1, 0, 0, 1'b1);
        plan[1]  = mk_row(ROW_STAMP, 64'd26616, 1'b1, 1, 1, 1'b0);
        plan[2]  = mk_row(ROW_STAMP, 64'd51615, 1'b1, 0, 1, 1'b0);   // remainder carries
        plan[3]  = mk_row(ROW_STAMP, 64'd0, 1'b0, 0, 0, 1'b0);       // wrap onto zero
        plan[4]  = mk_row(ROW_STAMP, {64{1'b1}}, 1'b0, 0, 0, 1'b0);  // primes again
        plan[5]  = mk_row(ROW_STAMP, 64'd5, 1'b0, 0, 0, 1'b0);
        plan[6]  = mk_row(ROW_STAMP, 64'd24999, 1'b0, 0, 0, 1'b0);   // advanced stamp wraps
        plan[7]  = mk_row(ROW_CFG, 64'(FREQ_TOP), 1'b0, 0, 0, 1'b0);
        plan[8]  = mk_row(ROW_DELTA, {64{1'b1}}, 1'b0, 0, 0, 1'b0);
        plan[9]  = mk_row(ROW_DELTA, 64'd17179869, 1'b0, 0, 0, 1'b0);
        plan[10] = mk_row(ROW_DELTA, 64'd17179870, 1'b0, 0, 0, 1'b0);
        plan[11] = mk_row(ROW_CFG, 64'd0, 1'b0, 0, 0, 1'b0);         // acts as minimum
        plan[12] = mk_row(ROW_DELTA, {64{1'b1}}, 1'b0, 0, 0, 1'b0);  // largest added_ms
        plan[13] = mk_row(ROW_DELTA, 64'd1000, 1'b0, 0, 0, 1'b0);
        plan[14] = mk_row(ROW_CFG, 64'(FREQ_MIN - 1), 1'b0, 0, 0, 1'b0);
        plan[15] = mk_row(ROW_DELTA, 64'd999, 1'b0, 0, 0, 1'b0);
        plan[16] = mk_row(ROW_DELTA, 64'd1000, 1'b0, 0, 0, 1'b0);
        plan[17] = mk_row(ROW_CFG, 64'(FREQ_MIN), 1'b0, 0, 0, 1'b0);
        plan[18] = mk_row(ROW_DELTA, 64'd1000, 1'b0, 0, 0, 1'b0);
        plan[19] = mk_row(ROW_CFG, 64'(FREQ_MIN + 1), 1'b0, 0, 0, 1'b0);
        plan[20] = mk_row(ROW_DELTA, 64'd0, 1'b0, 0, 0, 1'b0);
        plan[21] = mk_row(ROW_DELTA, 64'h8000_0000_0000_0000, 1'b0, 0, 0, 1'b0);
        plan[22] = mk_row(ROW_CFG, 64'(FREQ_RESET), 1'b0, 0, 0, 1'b0);
        plan[23] = mk_row(ROW_DELTA, 64'd75007, 1'b0, 0, 0, 1'b0);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < ROWS; i++) begin
            case (plan[i].kind)
                ROW_CFG:   write_freq(plan[i].value[FREQ_W-1:0]);
                ROW_DELTA: send_stamp(stored_stamp + plan[i].value, 1'b0, '0);
                default:   send_stamp(plan[i].value, plan[i].typed, plan[i].beat);
            endcase
        end

        // random part: sender light / receiver heavy, then swapped, then no idling
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 82 : 0;
            recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 15 : 0;
            for (sub = 0; sub < 4; sub++) begin
                write_freq(pick_freq());
                for (n = 0; n < 50; n++) begin
                    if ($urandom_range(99) < 2) drain_results();
                    send_stamp(pick_stamp(), 1'b0, '0);
                end
            end
        end

        // back-to-back full-span ticks at the minimum frequency, largest credit per beat
        write_freq('0);
        for (n = 0; n < 330; n++)
            send_stamp(stored_stamp - 64'($urandom_range(1, 4)), 1'b0, '0);

        drain_results();
        repeat (150) @(posedge i_clk);

        $display("%0d stamp beats (%0d priming), %0d results checked, %0d frequency writes",
                 beats_sent, primes_seen, results_seen, freq_writes);
        $display("running total wrapped %0d time(s), %0d mismatching beats",
                 total_wraps, mismatches);
        if (mismatches == 0 && pending_ms.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
